>>> rtl/core/tnb_pkg.sv
// Package for the triangle normal and bounding box core.
// Holds the types passed between the front stage and the normal engine. No dependencies.
package tnb_pkg;

    // Fixed port width of every coordinate and output field.
    localparam int FIELD_W = 16;
    // Magnitudes are shifted below this many bits before squaring.
    localparam int MAG_W   = 24;
    // Sum of three squares, shifted left by twelve for the Q.6 root.
    localparam int SUM_W   = 2 * MAG_W + 2 + 12;
    // Root of the shifted sum.
    localparam int ROOT_W  = SUM_W / 2;

    // Item passed from the front stage to the normal engine.
    typedef struct packed {
        logic [FIELD_W-1:0] min_x;
        logic [FIELD_W-1:0] min_y;
        logic [FIELD_W-1:0] min_z;
        logic [FIELD_W-1:0] max_x;
        logic [FIELD_W-1:0] max_y;
        logic [FIELD_W-1:0] max_z;
    } box_t;

endpackage

>>> rtl/core/tnb_front.sv
// Front stage: accepts a triangle, forms the edge vectors, updates the running box.
// Depends on tnb_pkg.
module tnb_front #(
    parameter int COORD_WIDTH = 16,
    parameter int EDGE_W = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_model,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic signed [EDGE_W-1:0]      q_e1 [3],
    output logic signed [EDGE_W-1:0]      q_e2 [3],
    output tnb_pkg::box_t                 q_box
);
    import tnb_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int ESH = (DIFF_W > 30) ? DIFF_W - 30 : 0;
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] lo_reg [3];
    logic signed [COORD_WIDTH-1:0] hi_reg [3];
    logic signed [COORD_WIDTH-1:0] lo_next [3];
    logic signed [COORD_WIDTH-1:0] hi_next [3];
    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];
    logic signed [EDGE_W-1:0]      e1_next [3];
    logic signed [EDGE_W-1:0]      e2_next [3];
    logic                          accept;

    assign va = '{ax, ay, az};
    assign vb = '{bx, by, bz};
    assign vc = '{cx, cy, cz};

    // Two-entry queue toward the engine.
    logic                     qv_reg [2];
    logic signed [EDGE_W-1:0] qe1_reg [2][3];
    logic signed [EDGE_W-1:0] qe2_reg [2][3];
    box_t                     qb_reg [2];
    box_t                     box_next;

    assign in_ready = !qv_reg[1];
    assign accept   = in_valid && in_ready;
    assign q_valid  = qv_reg[0];
    assign q_e1     = qe1_reg[0];
    assign q_e2     = qe2_reg[0];
    assign q_box    = qb_reg[0];

    function automatic logic signed [EDGE_W-1:0] shrink(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        logic [DIFF_W-1:0] s;
        begin
            m = d[DIFF_W-1] ? -d : d;
            s = m >> ESH;
            shrink = d[DIFF_W-1] ? -EDGE_W'(s) : EDGE_W'(s);
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_next[i] = start_model ? CMAX : lo_reg[i];
            hi_next[i] = start_model ? CMIN : hi_reg[i];
            if (va[i] < lo_next[i]) lo_next[i] = va[i];
            if (vb[i] < lo_next[i]) lo_next[i] = vb[i];
            if (vc[i] < lo_next[i]) lo_next[i] = vc[i];
            if (va[i] > hi_next[i]) hi_next[i] = va[i];
            if (vb[i] > hi_next[i]) hi_next[i] = vb[i];
            if (vc[i] > hi_next[i]) hi_next[i] = vc[i];
            e1_next[i] = shrink(DIFF_W'(va[i]) - DIFF_W'(vb[i]));
            e2_next[i] = shrink(DIFF_W'(vc[i]) - DIFF_W'(vb[i]));
        end
        box_next.min_x = FIELD_W'(lo_next[0]);
        box_next.min_y = FIELD_W'(lo_next[1]);
        box_next.min_z = FIELD_W'(lo_next[2]);
        box_next.max_x = FIELD_W'(hi_next[0]);
        box_next.max_y = FIELD_W'(hi_next[1]);
        box_next.max_z = FIELD_W'(hi_next[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= CMAX;
                hi_reg[i] <= CMIN;
            end
            qv_reg[0] <= 1'b0;
            qv_reg[1] <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
            // Pop head, shift, push at the first free slot.
            if (qv_reg[0] && q_ready)
            begin
                qv_reg[0]  <= qv_reg[1] || accept;
                qv_reg[1]  <= qv_reg[1] && accept;
                qe1_reg[0] <= qv_reg[1] ? qe1_reg[1] : e1_next;
                qe2_reg[0] <= qv_reg[1] ? qe2_reg[1] : e2_next;
                qb_reg[0]  <= qv_reg[1] ? qb_reg[1] : box_next;
                if (qv_reg[1] && accept)
                begin
                    qe1_reg[1] <= e1_next;
                    qe2_reg[1] <= e2_next;
                    qb_reg[1]  <= box_next;
                end
            end
            else if (accept)
            begin
                if (!qv_reg[0])
                begin
                    qv_reg[0]  <= 1'b1;
                    qe1_reg[0] <= e1_next;
                    qe2_reg[0] <= e2_next;
                    qb_reg[0]  <= box_next;
                end
                else
                begin
                    qv_reg[1]  <= 1'b1;
                    qe1_reg[1] <= e1_next;
                    qe2_reg[1] <= e2_next;
                    qb_reg[1]  <= box_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rst_n)
        begin
            assert (!(qv_reg[1] && !qv_reg[0]))
                else $error("queue tail valid without head");
        end
    end

    property p_full_blocks;
        @(posedge clk) disable iff (!rst_n) qv_reg[1] |-> !in_ready;
    endproperty
    a_full_blocks: assert property (p_full_blocks) else $error("accept while queue full");

    property p_box_order;
        @(posedge clk) disable iff (!rst_n)
            $past(accept) && $past(rst_n) |-> (lo_reg[0] <= hi_reg[0]);
    endproperty
    a_box_order: assert property (p_box_order) else $error("box min above max");

    property p_head_holds;
        @(posedge clk) disable iff (!rst_n)
            q_valid && !q_ready |=> q_valid;
    endproperty
    a_head_holds: assert property (p_head_holds) else $error("queue head lost");

endmodule

>>> rtl/core/tnb_engine.sv
// Back stage: cross product, scaling, iterative square root and three divisions (skipped for a degenerate triangle).
// Depends on tnb_pkg.
module tnb_engine #(
    parameter int NORMAL_FRAC_BITS = 14,
    parameter int EDGE_W = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic signed [EDGE_W-1:0] q_e1 [3],
    input  logic signed [EDGE_W-1:0] q_e2 [3],
    input  tnb_pkg::box_t            q_box,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              nx,
    output logic [15:0]              ny,
    output logic [15:0]              nz,
    output logic                     degen,
    output tnb_pkg::box_t            out_box
);
    import tnb_pkg::*;

    localparam int PROD_W = 2 * EDGE_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int SH_W   = $clog2(CR_W + 1);
    // One spare bit so the rounding term added to the scaled magnitude cannot carry out.
    localparam int NUM_W  = MAG_W + NORMAL_FRAC_BITS + 6 + 1;
    localparam int DIV_W  = NUM_W + 1;
    localparam int CNT_W  = $clog2(DIV_W + ROOT_W + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CROSS = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_SQ    = 3'd4;
    localparam logic [2:0] ST_ROOT  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]               state_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    box_t                     box_reg;
    logic signed [PROD_W-1:0] p_reg [6];
    logic [CR_W-1:0]          m_reg [3];
    logic                     neg_reg [3];
    logic [SH_W-1:0]          sh_reg;
    logic [MAG_W-1:0]         ms_reg [3];
    logic [SUM_W-1:0]         x_reg;
    logic [SUM_W-1:0]         bit_reg;
    logic [SUM_W-1:0]         res_reg;
    logic [1:0]               idx_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [15:0]              n_reg [3];
    logic                     degen_reg;
    logic [CR_W-1:0]          cr [3];
    logic [CR_W-1:0]          orm;
    logic [SUM_W-1:0]         sq_sum;
    logic [DIV_W-1:0]         rem_next;
    logic [NORMAL_FRAC_BITS:0] lim;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign nx        = n_reg[0];
    assign ny        = n_reg[1];
    assign nz        = n_reg[2];
    assign degen     = degen_reg;
    assign out_box   = box_reg;

    always_comb
    begin
        cr[0] = CR_W'(p_reg[0]) - CR_W'(p_reg[1]);
        cr[1] = CR_W'(p_reg[2]) - CR_W'(p_reg[3]);
        cr[2] = CR_W'(p_reg[4]) - CR_W'(p_reg[5]);
        orm   = m_reg[0] | m_reg[1] | m_reg[2];
        sq_sum = '0;
        for (int i = 0; i < 3; i++)
            sq_sum = sq_sum + SUM_W'(ms_reg[i] * ms_reg[i]);
        rem_next = {rem_reg[DIV_W-2:0], quo_reg[NUM_W-1]};
        if ((DIV_W)'(rem_next) >= DIV_W'(res_reg))
            rem_next = rem_next - DIV_W'(res_reg);
        lim = (quo_reg > NUM_W'(1 << NORMAL_FRAC_BITS)) ?
              (NORMAL_FRAC_BITS+1)'(1 << NORMAL_FRAC_BITS) : quo_reg[NORMAL_FRAC_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        e1_reg    <= q_e1;
                        e2_reg    <= q_e2;
                        box_reg   <= q_box;
                        state_reg <= ST_MUL;
                    end
                ST_MUL:
                begin
                    p_reg[0] <= e1_reg[1] * e2_reg[2];
                    p_reg[1] <= e1_reg[2] * e2_reg[1];
                    p_reg[2] <= e1_reg[2] * e2_reg[0];
                    p_reg[3] <= e1_reg[0] * e2_reg[2];
                    p_reg[4] <= e1_reg[0] * e2_reg[1];
                    p_reg[5] <= e1_reg[1] * e2_reg[0];
                    state_reg <= ST_CROSS;
                end
                ST_CROSS:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= cr[i][CR_W-1];
                        m_reg[i]   <= cr[i][CR_W-1] ? -cr[i] : cr[i];
                    end
                    sh_reg    <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    // Shift one bit per cycle until every magnitude fits.
                    if ((orm >> sh_reg) >= (CR_W'(1) << MAG_W))
                        sh_reg <= sh_reg + 1'b1;
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            ms_reg[i] <= MAG_W'(m_reg[i] >> sh_reg);
                        degen_reg <= (orm == '0);
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    x_reg     <= sq_sum << 12;
                    res_reg   <= '0;
                    bit_reg   <= SUM_W'(1) << (SUM_W - 2);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (bit_reg == '0)
                    begin
                        idx_reg   <= '0;
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        quo_reg   <= (NUM_W'(ms_reg[0]) << (NORMAL_FRAC_BITS + 6))
                                     + NUM_W'(res_reg >> 1);
                        state_reg <= degen_reg ? ST_OUT : ST_DIV;
                        if (degen_reg)
                            for (int i = 0; i < 3; i++)
                                n_reg[i] <= '0;
                    end
                    else
                    begin
                        if (x_reg >= res_reg + bit_reg)
                        begin
                            x_reg   <= x_reg - (res_reg + bit_reg);
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (cnt_reg == CNT_W'(NUM_W))
                    begin
                        n_reg[idx_reg] <= neg_reg[idx_reg] ? -16'(lim) : 16'(lim);
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        if (idx_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            quo_reg <= (NUM_W'(ms_reg[idx_reg + 1'b1]) << (NORMAL_FRAC_BITS + 6))
                                       + NUM_W'(res_reg >> 1);
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        quo_reg <= {quo_reg[NUM_W-2:0],
                                    ({rem_reg[DIV_W-2:0], quo_reg[NUM_W-1]} >= DIV_W'(res_reg))};
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT:
                    if (out_ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    property p_out_holds;
        @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid && $stable(nx);
    endproperty
    a_out_holds: assert property (p_out_holds) else $error("result changed while stalled");

    property p_degen_zero;
        @(posedge clk) disable iff (!rst_n) out_valid && degen |-> (nx == '0 && ny == '0 && nz == '0);
    endproperty
    a_degen_zero: assert property (p_degen_zero) else $error("degenerate normal not zero");

    property p_take_idle;
        @(posedge clk) disable iff (!rst_n) q_valid && q_ready |=> state_reg == ST_MUL;
    endproperty
    a_take_idle: assert property (p_take_idle) else $error("engine missed item");

endmodule

>>> rtl/core/triangle_normal_and_bounds_core.sv
// Top level of the triangle normal and bounding box core.
// Depends on tnb_pkg, tnb_front and tnb_engine.
//
//  channel  handshake          payload
//  input    in_valid/in_ready  start_model, corner_a/b/c_x/y/z
//  output   out_valid/out_ready normal_x/y/z, degenerate, box_min/max_x/y/z
//
// An item holds the engine from the take through a product step, a
// cross-product step, the normalizing shift steps, a squaring step, the
// iterative square root and three restoring divisions to the result
// state. A degenerate triangle skips the divisions. The front takes an item
// per cycle into a two-entry queue and stalls the input while both entries
// hold items.
// Reset clears the box to empty and the queue.
module triangle_normal_and_bounds_core #(
    parameter int COORD_WIDTH = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_model,
    input  logic [15:0] corner_a_x,
    input  logic [15:0] corner_a_y,
    input  logic [15:0] corner_a_z,
    input  logic [15:0] corner_b_x,
    input  logic [15:0] corner_b_y,
    input  logic [15:0] corner_b_z,
    input  logic [15:0] corner_c_x,
    input  logic [15:0] corner_c_y,
    input  logic [15:0] corner_c_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] normal_x,
    output logic [15:0] normal_y,
    output logic [15:0] normal_z,
    output logic        degenerate,
    output logic [15:0] box_min_x,
    output logic [15:0] box_min_y,
    output logic [15:0] box_min_z,
    output logic [15:0] box_max_x,
    output logic [15:0] box_max_y,
    output logic [15:0] box_max_z
);
    import tnb_pkg::*;

    localparam int EDGE_W = (COORD_WIDTH + 1 > 30) ? 30 : COORD_WIDTH + 1;

    logic                     q_valid;
    logic                     q_ready;
    logic signed [EDGE_W-1:0] q_e1 [3];
    logic signed [EDGE_W-1:0] q_e2 [3];
    box_t                     q_box;
    box_t                     out_box;

    tnb_front #(.COORD_WIDTH(COORD_WIDTH), .EDGE_W(EDGE_W)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .start_model,
        .ax(COORD_WIDTH'(signed'(corner_a_x))), .ay(COORD_WIDTH'(signed'(corner_a_y))),
        .az(COORD_WIDTH'(signed'(corner_a_z))), .bx(COORD_WIDTH'(signed'(corner_b_x))),
        .by(COORD_WIDTH'(signed'(corner_b_y))), .bz(COORD_WIDTH'(signed'(corner_b_z))),
        .cx(COORD_WIDTH'(signed'(corner_c_x))), .cy(COORD_WIDTH'(signed'(corner_c_y))),
        .cz(COORD_WIDTH'(signed'(corner_c_z))),
        .q_valid, .q_ready, .q_e1, .q_e2, .q_box
    );

    tnb_engine #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS), .EDGE_W(EDGE_W)) u_engine (
        .clk, .rst_n, .q_valid, .q_ready, .q_e1, .q_e2, .q_box,
        .out_valid, .out_ready,
        .nx(normal_x), .ny(normal_y), .nz(normal_z), .degen(degenerate), .out_box
    );

    assign box_min_x = out_box.min_x;
    assign box_min_y = out_box.min_y;
    assign box_min_z = out_box.min_z;
    assign box_max_x = out_box.max_x;
    assign box_max_y = out_box.max_y;
    assign box_max_z = out_box.max_z;

endmodule
